[design/sgd_pkg.sv]
// sgd_pkg: shared types, register codes and constants of the sobel gradient block
// used by every module of the block; depends on nothing

package sgd_pkg;

   localparam int MAX_WIDTH = 2048;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int WIDTH_W   = 12;
   localparam int HEIGHT_W  = 13;
   localparam int ROW_W     = 12;
   localparam int CSR_W     = 13;
   localparam int QDEPTH    = 4;
   localparam int QPTR_W    = $clog2(QDEPTH);
   localparam int QCNT_W    = $clog2(QDEPTH + 1);

   localparam logic [WIDTH_W-1:0]  WIDTH_MIN   = WIDTH_W'(3);
   localparam logic [WIDTH_W-1:0]  WIDTH_MAX   = WIDTH_W'(MAX_WIDTH);
   localparam logic [HEIGHT_W-1:0] HEIGHT_MIN  = HEIGHT_W'(3);
   localparam logic [HEIGHT_W-1:0] HEIGHT_MAX  = HEIGHT_W'(4096);

   // tan(pi/8) and tan(3pi/8) in q16
   localparam logic [24:0] TAN_LO = 25'd27146;
   localparam logic [27:0] TAN_HI = 28'd158218;

   localparam logic [1:0] CSR_LINE_WIDTH     = 2'd0;
   localparam logic [1:0] CSR_FRAME_HEIGHT   = 2'd1;
   localparam logic [1:0] CSR_EDGE_MODE      = 2'd2;
   localparam logic [1:0] CSR_MAGNITUDE_MODE = 2'd3;

   localparam logic [1:0] EDGE_BOTH    = 2'd0;
   localparam logic [1:0] EDGE_GX_ONLY = 2'd1;
   localparam logic [1:0] EDGE_GY_ONLY = 2'd2;

   localparam logic [1:0] DIR_DIAG_UP   = 2'd0;
   localparam logic [1:0] DIR_DIAG_DOWN = 2'd1;
   localparam logic [1:0] DIR_HORIZ     = 2'd2;
   localparam logic [1:0] DIR_VERT      = 2'd3;

   typedef struct packed {
      logic [7:0] pixel;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic signed [11:0] gradient;
      logic [1:0]         direction;
      logic [ROW_W-1:0]   out_row;
      logic [COL_W-1:0]   out_col;
      logic               frame_last;
   } rsp_type;

   typedef struct packed {
      logic [WIDTH_W-1:0]  line_width;
      logic [HEIGHT_W-1:0] frame_height;
      logic [1:0]          edge_mode;
      logic                magnitude_mode;
   } cfg_type;

   // one full 3x3 window minus the unused center tap, plus result position
   typedef struct packed {
      logic [7:0]       a00;
      logic [7:0]       a10;
      logic [7:0]       a20;
      logic [7:0]       a01;
      logic [7:0]       a21;
      logic [7:0]       a02;
      logic [7:0]       a12;
      logic [7:0]       a22;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             last;
   } win_type;

endpackage

[design/sgd_front.sv]
// sgd_front: raster counters, line stores and window taps of the sobel block
// depends on sgd_pkg; pushes finished windows into sgd_queue

module sgd_front
   import sgd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              req_push,
   input  req_type           req_data,
   output logic              req_full,
   input  logic [QCNT_W-1:0] q_count,
   output logic              win_push,
   output win_type           win_data
);

   logic [7:0] line_upper_ff  [MAX_WIDTH];
   logic [7:0] line_middle_ff [MAX_WIDTH];

   logic [COL_W-1:0] col_count_ff, col_count_in;
   logic [ROW_W-1:0] row_count_ff, row_count_in;
   logic [7:0]       taps_ff [6];

   logic             a_valid_ff;
   logic [7:0]       a_pixel_ff;
   logic [COL_W-1:0] a_col_ff;
   logic [ROW_W-1:0] a_row_ff;
   logic             a_emit_ff;
   logic             a_last_ff;
   logic [7:0]       up_rd_ff, mid_rd_ff;
   logic             fwd_ff;
   logic [7:0]       fwd_up_ff, fwd_mid_ff;

   logic [WIDTH_W-1:0]  w_eff;
   logic [HEIGHT_W-1:0] h_eff;
   logic [COL_W-1:0]    w_last, col_raw, col_c;
   logic [ROW_W-1:0]    h_last, row_c;
   logic                accept;
   logic [7:0]          up, mid;

   always_comb begin
      w_eff = cfg.line_width;
      if (w_eff < WIDTH_MIN) w_eff = WIDTH_MIN;
      if (w_eff > WIDTH_MAX) w_eff = WIDTH_MAX;
      h_eff = cfg.frame_height;
      if (h_eff < HEIGHT_MIN) h_eff = HEIGHT_MIN;
      if (h_eff > HEIGHT_MAX) h_eff = HEIGHT_MAX;
   end

   assign w_last = COL_W'(w_eff - WIDTH_W'(1));
   assign h_last = ROW_W'(h_eff - HEIGHT_W'(1));

   // room is reserved for the beat still in the read stage
   assign req_full = (QCNT_W'(q_count + QCNT_W'(a_valid_ff)) >= QCNT_W'(QDEPTH));
   assign accept   = req_push && !req_full;

   always_comb begin
      col_raw = req_data.frame_start ? '0 : col_count_ff;
      row_c   = req_data.frame_start ? '0 : row_count_ff;
      col_c   = ({1'b0, col_raw} >= w_eff) ? w_last : col_raw;
      if (col_c == w_last) begin
         col_count_in = '0;
         row_count_in = (row_c >= h_last) ? '0 : ROW_W'(row_c + ROW_W'(1));
      end else begin
         col_count_in = COL_W'(col_c + COL_W'(1));
         row_count_in = row_c;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= '0;
         row_count_ff <= '0;
      end else if (accept) begin
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
      end
   end

   // line store reads, registered
   always_ff @(posedge clock) begin
      if (accept) begin
         up_rd_ff  <= line_upper_ff[col_c];
         mid_rd_ff <= line_middle_ff[col_c];
      end
   end

   // same column written by the beat ahead on this edge: bypass the store
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else begin
         fwd_ff <= accept && a_valid_ff && (col_c == a_col_ff);
      end
      fwd_up_ff  <= mid;
      fwd_mid_ff <= a_pixel_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= accept;
      end
      if (accept) begin
         a_pixel_ff <= req_data.pixel;
         a_col_ff   <= col_c;
         a_row_ff   <= row_c;
         a_emit_ff  <= (row_c >= ROW_W'(2)) && (col_c >= COL_W'(2));
         a_last_ff  <= (row_c == h_last) && (col_c == w_last);
      end
   end

   assign up  = fwd_ff ? fwd_up_ff  : up_rd_ff;
   assign mid = fwd_ff ? fwd_mid_ff : mid_rd_ff;

   always_ff @(posedge clock) begin
      if (a_valid_ff) begin
         line_upper_ff[a_col_ff]  <= mid;
         line_middle_ff[a_col_ff] <= a_pixel_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) taps_ff[i] <= '0;
      end else if (a_valid_ff) begin
         taps_ff[0] <= taps_ff[3];
         taps_ff[1] <= taps_ff[4];
         taps_ff[2] <= taps_ff[5];
         taps_ff[3] <= up;
         taps_ff[4] <= mid;
         taps_ff[5] <= a_pixel_ff;
      end
   end

   assign win_push = a_valid_ff && a_emit_ff;

   always_comb begin
      win_data.a00  = taps_ff[0];
      win_data.a10  = taps_ff[1];
      win_data.a20  = taps_ff[2];
      win_data.a01  = taps_ff[3];
      win_data.a21  = taps_ff[5];
      win_data.a02  = up;
      win_data.a12  = mid;
      win_data.a22  = a_pixel_ff;
      win_data.row  = ROW_W'(a_row_ff - ROW_W'(1));
      win_data.col  = COL_W'(a_col_ff - COL_W'(1));
      win_data.last = a_last_ff;
   end

endmodule

[design/sgd_queue.sv]
// sgd_queue: short window queue between the front and back of the sobel block
// depends on sgd_pkg for the entry type and depth

module sgd_queue
   import sgd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  win_type           push_data,
   input  logic              pop,
   output logic              head_valid,
   output win_type           head_data,
   output logic [QCNT_W-1:0] count
);

   win_type           entry_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_pop;

   assign do_pop     = pop && (count_ff != '0);
   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];
   assign count      = count_ff;

   always_comb begin
      wr_ptr_in = push   ? QPTR_W'(wr_ptr_ff + QPTR_W'(1)) : wr_ptr_ff;
      rd_ptr_in = do_pop ? QPTR_W'(rd_ptr_ff + QPTR_W'(1)) : rd_ptr_ff;
      count_in  = QCNT_W'(count_ff + QCNT_W'(push) - QCNT_W'(do_pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

[design/sgd_back.sv]
// sgd_back: sobel gradients, edge strength and direction sector, with result register
// depends on sgd_pkg; pops windows from sgd_queue

module sgd_back
   import sgd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    win_valid,
   input  win_type win_data,
   output logic    win_pop,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   // gradient stage
   logic               c_valid_ff;
   logic signed [10:0] c_gx_ff, c_gy_ff;
   logic [ROW_W-1:0]   c_row_ff;
   logic [COL_W-1:0]   c_col_ff;
   logic               c_last_ff;
   // multiply stage
   logic               d_valid_ff;
   logic signed [11:0] d_g_ff;
   logic signed [10:0] d_ys_ff;
   logic [24:0]        d_lo_ff;
   logic [27:0]        d_hi_ff;
   logic               d_gx_zero_ff;
   logic [ROW_W-1:0]   d_row_ff;
   logic [COL_W-1:0]   d_col_ff;
   logic               d_last_ff;
   // result register
   logic               o_valid_ff;
   rsp_type            o_data_ff;

   logic c_ready, d_ready, o_ready;

   assign o_ready = !o_valid_ff || rsp_pop;
   assign d_ready = !d_valid_ff || o_ready;
   assign c_ready = !c_valid_ff || d_ready;
   assign win_pop = win_valid && c_ready;

   function automatic logic signed [10:0] px(input logic [7:0] p);
      px = $signed({3'b000, p});
   endfunction

   logic signed [10:0] gx_in, gy_in;

   always_comb begin
      gx_in = '0;
      gy_in = '0;
      if (cfg.edge_mode != EDGE_GY_ONLY)
         gx_in = (px(win_data.a02) - px(win_data.a00))
               + ((px(win_data.a12) - px(win_data.a10)) <<< 1)
               + (px(win_data.a22) - px(win_data.a20));
      if (cfg.edge_mode != EDGE_GX_ONLY)
         gy_in = (px(win_data.a20) + (px(win_data.a21) <<< 1) + px(win_data.a22))
               - (px(win_data.a00) + (px(win_data.a01) <<< 1) + px(win_data.a02));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (c_ready) begin
         c_valid_ff <= win_valid;
      end
      if (c_ready && win_valid) begin
         c_gx_ff   <= gx_in;
         c_gy_ff   <= gy_in;
         c_row_ff  <= win_data.row;
         c_col_ff  <= win_data.col;
         c_last_ff <= win_data.last;
      end
   end

   logic signed [10:0] ax, ay, ys_in;
   logic signed [11:0] g_in;
   logic [9:0]         x;

   always_comb begin
      ax    = c_gx_ff[10] ? -c_gx_ff : c_gx_ff;
      ay    = c_gy_ff[10] ? -c_gy_ff : c_gy_ff;
      ys_in = c_gx_ff[10] ? -c_gy_ff : c_gy_ff;
      x     = ax[9:0];
      if (cfg.magnitude_mode)
         g_in = 12'(ax) + 12'(ay);
      else
         g_in = 12'(c_gx_ff) + 12'(c_gy_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (d_ready) begin
         d_valid_ff <= c_valid_ff;
      end
      if (d_ready && c_valid_ff) begin
         d_g_ff       <= g_in;
         d_ys_ff      <= ys_in;
         d_lo_ff      <= {15'd0, x} * TAN_LO;
         d_hi_ff      <= {18'd0, x} * TAN_HI;
         d_gx_zero_ff <= (c_gx_ff == '0);
         d_row_ff     <= c_row_ff;
         d_col_ff     <= c_col_ff;
         d_last_ff    <= c_last_ff;
      end
   end

   logic signed [28:0] yq, lo_s, hi_s;
   logic [1:0]         dir_in;

   always_comb begin
      yq   = $signed({{2{d_ys_ff[10]}}, d_ys_ff, 16'd0});
      lo_s = $signed({4'd0, d_lo_ff});
      hi_s = $signed({1'b0, d_hi_ff});
      // bounds themselves fall through to vertical
      if (d_gx_zero_ff)
         dir_in = DIR_VERT;
      else if (yq > -hi_s && yq < -lo_s)
         dir_in = DIR_DIAG_UP;
      else if (yq > -lo_s && yq < lo_s)
         dir_in = DIR_HORIZ;
      else if (yq > lo_s && yq < hi_s)
         dir_in = DIR_DIAG_DOWN;
      else
         dir_in = DIR_VERT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (o_ready) begin
         o_valid_ff <= d_valid_ff;
      end
      if (o_ready && d_valid_ff) begin
         o_data_ff.gradient   <= d_g_ff;
         o_data_ff.direction  <= dir_in;
         o_data_ff.out_row    <= d_row_ff;
         o_data_ff.out_col    <= d_col_ff;
         o_data_ff.frame_last <= d_last_ff;
      end
   end

   assign rsp_empty = !o_valid_ff;
   assign rsp_data  = o_data_ff;

endmodule

[design/sobel_gradient_direction.sv]
// sobel_gradient_direction: top level, register file and wiring of front, queue and back
// depends on sgd_pkg, sgd_front, sgd_queue and sgd_back
//
//   channel   ports                          beat
//   request   req_push  req_full  req_data   one pixel with frame start flag
//   response  rsp_pop   rsp_empty rsp_data   one interior pixel result
//   csr       csr_we    csr_addr  csr_wdata  one register write, no read-back
//
// one pixel per clock sustained while rsp_pop drains results; a result passes through
// the read stage, queue, gradient, multiply and result register on its way to rsp_data.
// req_full rises once the window queue and the read stage together hold four beats;
// the back end holds three more results before a stalled rsp side stops the queue.
// synchronous reset clears counters, taps and all valid state; no clearing pass.

module sobel_gradient_direction
   import sgd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  req_type          req_data,
   output logic             req_full,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output rsp_type          rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_addr,
   input  logic [CSR_W-1:0] csr_wdata
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.line_width     <= WIDTH_W'(640);
         cfg_ff.frame_height   <= HEIGHT_W'(480);
         cfg_ff.edge_mode      <= EDGE_BOTH;
         cfg_ff.magnitude_mode <= 1'b1;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_LINE_WIDTH:     cfg_ff.line_width     <= csr_wdata[WIDTH_W-1:0];
            CSR_FRAME_HEIGHT:   cfg_ff.frame_height   <= csr_wdata[HEIGHT_W-1:0];
            CSR_EDGE_MODE:      cfg_ff.edge_mode      <= csr_wdata[1:0];
            CSR_MAGNITUDE_MODE: cfg_ff.magnitude_mode <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   logic              win_push, win_pop, head_valid;
   win_type           win_data, head_data;
   logic [QCNT_W-1:0] q_count;

   sgd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .q_count  (q_count),
      .win_push (win_push),
      .win_data (win_data)
   );

   sgd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (win_push),
      .push_data  (win_data),
      .pop        (win_pop),
      .head_valid (head_valid),
      .head_data  (head_data),
      .count      (q_count)
   );

   sgd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .win_valid (head_valid),
      .win_data  (head_data),
      .win_pop   (win_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
